// ===== sv/bbpf_pkg.sv =====
`timescale 1ns / 1ps

package bbpf_pkg;

    localparam int LEN_W   = 16;
    localparam int HDL_W   = 16;
    localparam int BYTES_W = 21;
    localparam int STAT_W  = 3;

    localparam int MAX_RESULTS = 16;
    localparam int RUN_W       = $clog2(MAX_RESULTS + 1);

    localparam logic [BYTES_W-1:0] RESET_CAPACITY = BYTES_W'(32768);

    localparam logic [STAT_W-1:0] ST_ADDED    = 3'd0;
    localparam logic [STAT_W-1:0] ST_NO_ROOM  = 3'd1;
    localparam logic [STAT_W-1:0] ST_EMPTY    = 3'd2;
    localparam logic [STAT_W-1:0] ST_FULL     = 3'd3;
    localparam logic [STAT_W-1:0] ST_DELIVER  = 3'd4;
    localparam logic [STAT_W-1:0] ST_NOTHING  = 3'd5;

    typedef struct packed {
        logic capture;   // input beat taken, latch payload and limit
        logic add;       // perform add and load its result
        logic pop;       // pop head descriptor into pending
        logic emit_pend; // move pending result to output
        logic pend_last; // last flag for emit_pend
        logic emit_none; // load a nothing-extracted result
    } t_dp_cmd;

    typedef struct packed {
        logic out_free;
        logic req_extract;
        logic ring_empty;
        logic run_max;
        logic run_zero;
        logic head_fits;
    } t_dp_sts;

    function automatic logic [BYTES_W-1:0] free_of(input logic [BYTES_W-1:0] cap,
                                                   input logic [BYTES_W-1:0] held);
        free_of = (cap > held) ? (cap - held) : '0;
    endfunction

endpackage

// ===== sv/bbpf_ctrl.sv =====
`timescale 1ns / 1ps

module bbpf_ctrl
    import bbpf_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_in_valid,
    output logic    o_in_ready,
    input  t_dp_sts i_sts,
    output t_dp_cmd o_cmd
);

    localparam logic [1:0] S_IDLE   = 2'd0;
    localparam logic [1:0] S_ADD    = 2'd1;
    localparam logic [1:0] S_EXT_RD = 2'd2;
    localparam logic [1:0] S_EXT_CK = 2'd3;

    logic [1:0] r_state;
    logic [1:0] n_state;
    logic       w_pop_ok;

    assign w_pop_ok = !i_sts.ring_empty && !i_sts.run_max && i_sts.head_fits;

    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_in_ready = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.capture = 1'b1;
                    n_state = i_sts.req_extract ? S_EXT_RD : S_ADD;
                end
            end
            S_ADD: begin
                if (i_sts.out_free) begin
                    o_cmd.add = 1'b1;
                    n_state   = S_IDLE;
                end
            end
            S_EXT_RD: begin
                n_state = S_EXT_CK;
            end
            S_EXT_CK: begin
                if (w_pop_ok) begin
                    if (i_sts.run_zero) begin
                        o_cmd.pop = 1'b1;
                        n_state   = S_EXT_RD;
                    end else if (i_sts.out_free) begin
                        o_cmd.pop       = 1'b1;
                        o_cmd.emit_pend = 1'b1;
                        n_state         = S_EXT_RD;
                    end
                end else if (i_sts.out_free) begin
                    if (i_sts.run_zero) begin
                        o_cmd.emit_none = 1'b1;
                    end else begin
                        o_cmd.emit_pend = 1'b1;
                        o_cmd.pend_last = 1'b1;
                    end
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

// ===== sv/bbpf_dp.sv =====
`timescale 1ns / 1ps

module bbpf_dp
    import bbpf_pkg::*;
#(
    parameter int QUEUE_DEPTH = 16
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  t_dp_cmd            i_cmd,
    output t_dp_sts            o_sts,
    input  logic               i_cfg_wr,
    input  logic [BYTES_W-1:0] i_cfg_data,
    input  logic               i_mode,
    input  logic [LEN_W-1:0]   i_packet_length,
    input  logic [HDL_W-1:0]   i_packet_handle,
    input  logic [BYTES_W-1:0] i_extract_budget,
    input  logic               i_out_ready,
    output logic               o_out_valid,
    output logic [STAT_W-1:0]  o_status,
    output logic [HDL_W-1:0]   o_out_handle,
    output logic [LEN_W-1:0]   o_out_length,
    output logic               o_last_of_run,
    output logic [BYTES_W-1:0] o_bytes_held_now,
    output logic [BYTES_W-1:0] o_bytes_free_now
);

    localparam int IDX_W = $clog2(QUEUE_DEPTH);
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(QUEUE_DEPTH - 1);
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(QUEUE_DEPTH);

    logic [HDL_W+LEN_W-1:0] r_ring [QUEUE_DEPTH];
    logic [HDL_W+LEN_W-1:0] r_rdata;

    logic [IDX_W-1:0]   r_head;
    logic [IDX_W-1:0]   r_tail;
    logic [CNT_W-1:0]   r_count;
    logic [BYTES_W-1:0] r_held;
    logic [BYTES_W-1:0] r_cap;

    logic [LEN_W-1:0]   r_len;
    logic [HDL_W-1:0]   r_hdl;
    logic [BYTES_W-1:0] r_limit;
    logic [BYTES_W-1:0] r_total;
    logic [RUN_W-1:0]   r_run;

    logic [HDL_W-1:0]   r_p_hdl;
    logic [LEN_W-1:0]   r_p_len;
    logic [BYTES_W-1:0] r_p_held;

    logic [LEN_W-1:0]   w_plen;
    logic [HDL_W-1:0]   w_phdl;
    logic [BYTES_W:0]   w_sum;
    logic [BYTES_W-1:0] w_free;
    logic [BYTES_W-1:0] w_add_held;
    logic [BYTES_W-1:0] w_pop_held;
    logic [STAT_W-1:0]  w_add_st;
    logic               w_add_ok;
    logic               w_load;

    assign w_plen = r_rdata[LEN_W-1:0];
    assign w_phdl = r_rdata[HDL_W+LEN_W-1:LEN_W];
    assign w_sum  = {1'b0, r_total} + (BYTES_W + 1)'(w_plen);
    assign w_free = free_of(r_cap, r_held);

    always_comb begin
        w_add_ok = 1'b0;
        if ((BYTES_W)'(r_len) > w_free) begin
            w_add_st = ST_NO_ROOM;
        end else if (r_len == '0) begin
            w_add_st = ST_EMPTY;
        end else if (r_count == FULL_CNT) begin
            w_add_st = ST_FULL;
        end else begin
            w_add_st = ST_ADDED;
            w_add_ok = 1'b1;
        end
    end

    assign w_add_held = w_add_ok ? (r_held + BYTES_W'(r_len)) : r_held;
    assign w_pop_held = (r_held >= BYTES_W'(w_plen)) ? (r_held - BYTES_W'(w_plen)) : '0;
    assign w_load     = i_cmd.add || i_cmd.emit_pend || i_cmd.emit_none;

    assign o_sts.out_free    = !o_out_valid || i_out_ready;
    assign o_sts.req_extract = i_mode;
    assign o_sts.ring_empty  = (r_count == '0);
    assign o_sts.run_max     = (r_run == RUN_W'(MAX_RESULTS));
    assign o_sts.run_zero    = (r_run == '0);
    assign o_sts.head_fits   = (w_sum <= {1'b0, r_limit});

    always_ff @(posedge i_clk) begin
        if (i_cmd.add && w_add_ok) begin
            r_ring[r_tail] <= {r_hdl, r_len};
        end
        r_rdata <= r_ring[r_head];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head      <= '0;
            r_tail      <= '0;
            r_count     <= '0;
            r_held      <= '0;
            r_cap       <= RESET_CAPACITY;
            o_out_valid <= 1'b0;
        end else begin
            if (i_cfg_wr) begin
                r_cap <= i_cfg_data;
            end
            if (i_cmd.add && w_add_ok) begin
                r_tail  <= (r_tail == LAST_IDX) ? '0 : r_tail + 1'b1;
                r_count <= r_count + 1'b1;
                r_held  <= w_add_held;
            end
            if (i_cmd.pop) begin
                r_head  <= (r_head == LAST_IDX) ? '0 : r_head + 1'b1;
                r_count <= r_count - 1'b1;
                r_held  <= w_pop_held;
            end
            if (w_load) begin
                o_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                o_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_len   <= i_packet_length;
            r_hdl   <= i_packet_handle;
            r_limit <= (i_extract_budget < r_held) ? i_extract_budget : r_held;
            r_total <= '0;
            r_run   <= '0;
        end
        if (i_cmd.pop) begin
            r_total  <= w_sum[BYTES_W-1:0];
            r_run    <= r_run + 1'b1;
            r_p_hdl  <= w_phdl;
            r_p_len  <= w_plen;
            r_p_held <= w_pop_held;
        end
        if (i_cmd.add) begin
            o_status         <= w_add_st;
            o_out_handle     <= '0;
            o_out_length     <= '0;
            o_last_of_run    <= 1'b1;
            o_bytes_held_now <= w_add_held;
            o_bytes_free_now <= free_of(r_cap, w_add_held);
        end else if (i_cmd.emit_pend) begin
            o_status         <= ST_DELIVER;
            o_out_handle     <= r_p_hdl;
            o_out_length     <= r_p_len;
            o_last_of_run    <= i_cmd.pend_last;
            o_bytes_held_now <= r_p_held;
            o_bytes_free_now <= free_of(r_cap, r_p_held);
        end else if (i_cmd.emit_none) begin
            o_status         <= ST_NOTHING;
            o_out_handle     <= '0;
            o_out_length     <= '0;
            o_last_of_run    <= 1'b1;
            o_bytes_held_now <= r_held;
            o_bytes_free_now <= w_free;
        end
    end

endmodule

// ===== sv/byte_budget_packet_fifo.sv =====
`timescale 1ns / 1ps

// Packet descriptor FIFO with byte accounting. An add (mode 0) queues a
// handle/length pair if the length is nonzero, fits the free bytes and a slot
// is open, and returns one status beat. An extract (mode 1) pops whole head
// packets while their sum stays within min(budget, bytes held), at most 16 per
// request; each popped packet is one beat, the final beat carries last_of_run,
// and a single nothing-extracted beat is returned when no packet fits. An add
// loads its result in the add state once the output is free. An extract
// passes a read state and a check state per popped packet, set by the
// registered read port of the descriptor ring, and loads its final beat in the
// check state; no new request is taken until the block is idle again. Output
// backpressure stalls the add and check states. The user must write capacity
// through the config channel only while the block is idle; it is not enforced.
module byte_budget_packet_fifo
    import bbpf_pkg::*;
#(
    parameter int QUEUE_DEPTH = 16
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_valid,
    output logic               o_cfg_ready,
    input  logic [BYTES_W-1:0] i_cfg_data,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  logic               i_mode,
    input  logic [LEN_W-1:0]   i_packet_length,
    input  logic [HDL_W-1:0]   i_packet_handle,
    input  logic [BYTES_W-1:0] i_extract_budget,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output logic [STAT_W-1:0]  o_status,
    output logic [HDL_W-1:0]   o_out_handle,
    output logic [LEN_W-1:0]   o_out_length,
    output logic               o_last_of_run,
    output logic [BYTES_W-1:0] o_bytes_held_now,
    output logic [BYTES_W-1:0] o_bytes_free_now
);

    t_dp_cmd w_cmd;
    t_dp_sts w_sts;

    assign o_cfg_ready = 1'b1;

    bbpf_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_sts      (w_sts),
        .o_cmd      (w_cmd)
    );

    bbpf_dp #(
        .QUEUE_DEPTH (QUEUE_DEPTH)
    ) u_dp (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cmd            (w_cmd),
        .o_sts            (w_sts),
        .i_cfg_wr         (i_cfg_valid),
        .i_cfg_data       (i_cfg_data),
        .i_mode           (i_mode),
        .i_packet_length  (i_packet_length),
        .i_packet_handle  (i_packet_handle),
        .i_extract_budget (i_extract_budget),
        .i_out_ready      (i_out_ready),
        .o_out_valid      (o_out_valid),
        .o_status         (o_status),
        .o_out_handle     (o_out_handle),
        .o_out_length     (o_out_length),
        .o_last_of_run    (o_last_of_run),
        .o_bytes_held_now (o_bytes_held_now),
        .o_bytes_free_now (o_bytes_free_now)
    );

endmodule

// ===== bench/tb.sv =====
`timescale 1ns / 1ps

module tb;
    import bbpf_pkg::*;

    localparam int                 DEPTH        = 16;
    localparam logic [BYTES_W-1:0] BYTES_MAX    = BYTES_W'(1048576);
    localparam logic               MODE_ADD     = 1'b0;
    localparam logic               MODE_EXTRACT = 1'b1;
    localparam int                 PHASES       = 8;
    localparam int                 PHASE_ITEMS  = 60;
    localparam int                 SETTLE       = 40;
    localparam int                 HOLD_CYCLES  = 400;
    localparam int                 IDLE_PCT     = 37;

    typedef struct packed {
        logic [STAT_W-1:0]  status;
        logic [HDL_W-1:0]   handle;
        logic [LEN_W-1:0]   length;
        logic               last;
        logic [BYTES_W-1:0] held;
        logic [BYTES_W-1:0] free_b;
    } t_result_beat;

    typedef struct packed {
        logic [HDL_W-1:0] handle;
        logic [LEN_W-1:0] length;
    } t_descriptor;

    // Tracks the descriptor queue and byte count, holds the beats still owed.
    class fifo_ledger;
        t_descriptor        queued[$];
        t_result_beat       due_beats[$];
        logic [BYTES_W-1:0] capacity;
        logic [BYTES_W-1:0] held;
        int                 mismatches;
        int                 requests;
        int                 beats_seen;
        int                 longest_run;
        int                 status_hits[6];

        function new();
            capacity    = RESET_CAPACITY;
            held        = '0;
            mismatches  = 0;
            requests    = 0;
            beats_seen  = 0;
            longest_run = 0;
            foreach (status_hits[i]) status_hits[i] = 0;
        endfunction

        function logic [BYTES_W-1:0] free_bytes();
            return (capacity > held) ? capacity - held : '0;
        endfunction

        function void queue_beat(logic [STAT_W-1:0] st, logic [HDL_W-1:0] hdl,
                                 logic [LEN_W-1:0] len, logic last);
            t_result_beat b;
            b.status = st;
            b.handle = hdl;
            b.length = len;
            b.last   = last;
            b.held   = held;
            b.free_b = free_bytes();
            due_beats.push_back(b);
        endfunction

        function void note_request(logic mode, logic [LEN_W-1:0] len,
                                   logic [HDL_W-1:0] hdl, logic [BYTES_W-1:0] budget);
            logic [BYTES_W-1:0] limit;
            int unsigned        total;
            int                 popped;
            t_descriptor        d;
            t_result_beat       tail;
            requests++;
            if (mode == MODE_ADD) begin
                if (len > free_bytes()) begin
                    queue_beat(ST_NO_ROOM, '0, '0, 1'b1);
                end else if (len == '0) begin
                    queue_beat(ST_EMPTY, '0, '0, 1'b1);
                end else if (queued.size() >= DEPTH) begin
                    queue_beat(ST_FULL, '0, '0, 1'b1);
                end else begin
                    d.handle = hdl;
                    d.length = len;
                    queued.push_back(d);
                    held = held + len;
                    queue_beat(ST_ADDED, '0, '0, 1'b1);
                end
                return;
            end
            limit  = (budget < held) ? budget : held;
            total  = 0;
            popped = 0;
            while (popped < MAX_RESULTS && queued.size() > 0 &&
                   total + queued[0].length <= limit) begin
                d = queued.pop_front();
                total += d.length;
                held = held - d.length;
                queue_beat(ST_DELIVER, d.handle, d.length, 1'b0);
                popped++;
            end
            if (popped == 0) begin
                queue_beat(ST_NOTHING, '0, '0, 1'b1);
            end else begin
                tail = due_beats.pop_back();
                tail.last = 1'b1;
                due_beats.push_back(tail);
            end
            if (popped > longest_run) longest_run = popped;
        endfunction

        task report(string what, longint got, longint want);
            mismatches++;
            if (mismatches <= 40)
                $display("mismatch at %0t: %s got %0d want %0d", $time, what, got, want);
        endtask

        task check_beat(t_result_beat got);
            t_result_beat want;
            beats_seen++;
            if (got.status < 6) status_hits[got.status]++;
            if (due_beats.size() == 0) begin
                report("beat with nothing outstanding, status", got.status, 0);
                return;
            end
            want = due_beats.pop_front();
            if (got.status !== want.status) report("status", got.status, want.status);
            if (got.handle !== want.handle) report("out_handle", got.handle, want.handle);
            if (got.length !== want.length) report("out_length", got.length, want.length);
            if (got.last !== want.last) report("last_of_run", got.last, want.last);
            if (got.held !== want.held) report("bytes_held_now", got.held, want.held);
            if (got.free_b !== want.free_b) report("bytes_free_now", got.free_b, want.free_b);
        endtask
    endclass

    logic               i_clk;
    logic               i_rst_n;
    logic               i_cfg_valid;
    logic               o_cfg_ready;
    logic [BYTES_W-1:0] i_cfg_data;
    logic               i_in_valid;
    logic               o_in_ready;
    logic               i_mode;
    logic [LEN_W-1:0]   i_packet_length;
    logic [HDL_W-1:0]   i_packet_handle;
    logic [BYTES_W-1:0] i_extract_budget;
    logic               o_out_valid;
    logic               i_out_ready;
    logic [STAT_W-1:0]  o_status;
    logic [HDL_W-1:0]   o_out_handle;
    logic [LEN_W-1:0]   o_out_length;
    logic               o_last_of_run;
    logic [BYTES_W-1:0] o_bytes_held_now;
    logic [BYTES_W-1:0] o_bytes_free_now;

    fifo_ledger ledger;
    bit         no_idle  = 1'b0;
    bit         hold_req = 1'b0;

    byte_budget_packet_fifo #(
        .QUEUE_DEPTH(DEPTH)
    ) u_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_valid     (i_cfg_valid),
        .o_cfg_ready     (o_cfg_ready),
        .i_cfg_data      (i_cfg_data),
        .i_in_valid      (i_in_valid),
        .o_in_ready      (o_in_ready),
        .i_mode          (i_mode),
        .i_packet_length (i_packet_length),
        .i_packet_handle (i_packet_handle),
        .i_extract_budget(i_extract_budget),
        .o_out_valid     (o_out_valid),
        .i_out_ready     (i_out_ready),
        .o_status        (o_status),
        .o_out_handle    (o_out_handle),
        .o_out_length    (o_out_length),
        .o_last_of_run   (o_last_of_run),
        .o_bytes_held_now(o_bytes_held_now),
        .o_bytes_free_now(o_bytes_free_now)
    );

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    task automatic send_request(input logic mode, input logic [LEN_W-1:0] len,
                                input logic [HDL_W-1:0] hdl,
                                input logic [BYTES_W-1:0] budget);
        i_in_valid       <= 1'b1;
        i_mode           <= mode;
        i_packet_length  <= len;
        i_packet_handle  <= hdl;
        i_extract_budget <= budget;
        do @(posedge i_clk); while (o_in_ready !== 1'b1);
        ledger.note_request(mode, len, hdl, budget);
    endtask

    task automatic pause_input();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
    endtask

    // Block goes idle: every owed beat back, then margin for the longest run.
    task automatic drain_results();
        i_in_valid <= 1'b0;
        while (ledger.due_beats.size() != 0) @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    task automatic write_capacity(input logic [BYTES_W-1:0] cap);
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= cap;
        do @(posedge i_clk); while (o_cfg_ready !== 1'b1);
        i_cfg_valid <= 1'b0;
        ledger.capacity = cap;
    endtask

    task automatic random_request();
        logic [LEN_W-1:0]   len;
        logic [BYTES_W-1:0] budget;
        int unsigned        pick;
        int unsigned        span;
        int unsigned        upto;
        int                 k;
        pick = $urandom_range(0, 99);
        if (pick < 60) begin
            pick = $urandom_range(0, 99);
            span = ledger.capacity / 8;
            if (span < 1) span = 1;
            if (span > 65535) span = 65535;
            if (pick < 5) len = '0;
            else if (pick < 10) len = '1;
            else if (pick < 20) len = LEN_W'($urandom);
            else if (pick < 60) len = LEN_W'($urandom_range(1, 64));
            else len = LEN_W'($urandom_range(1, span));
            send_request(MODE_ADD, len, HDL_W'($urandom),
                         BYTES_W'($urandom_range(0, BYTES_MAX)));
        end else begin
            pick = $urandom_range(0, 99);
            upto = 0;
            if (pick < 10) begin
                budget = '0;
            end else if (pick < 20) begin
                budget = BYTES_MAX;
            end else if (pick < 30) begin
                budget = BYTES_W'($urandom_range(0, BYTES_MAX));
            end else if (pick < 55) begin
                budget = BYTES_W'($urandom_range(0, ledger.held));
            end else if (pick < 65) begin
                upto = ledger.held + $urandom_range(0, 1000);
                budget = (upto > BYTES_MAX) ? BYTES_MAX : BYTES_W'(upto);
            end else begin
                // exact sum of the first few queued packets, or one byte short
                k = (ledger.queued.size() > 0) ? $urandom_range(1, ledger.queued.size()) : 0;
                for (int i = 0; i < k; i++) upto += ledger.queued[i].length;
                budget = (pick < 85 || upto == 0) ? BYTES_W'(upto) : BYTES_W'(upto - 1);
            end
            send_request(MODE_EXTRACT, LEN_W'($urandom), HDL_W'($urandom), budget);
        end
    endtask

    initial begin
        t_result_beat got;
        i_out_ready = 1'b0;
        forever begin
            @(posedge i_clk);
            if (o_out_valid === 1'b1 && i_out_ready === 1'b1) begin
                got.status = o_status;
                got.handle = o_out_handle;
                got.length = o_out_length;
                got.last   = o_last_of_run;
                got.held   = o_bytes_held_now;
                got.free_b = o_bytes_free_now;
                ledger.check_beat(got);
            end
            if (hold_req) begin
                i_out_ready <= 1'b0;
                for (int c = 0; c < HOLD_CYCLES; c++) @(posedge i_clk);
                hold_req = 1'b0;
            end else begin
                i_out_ready <= no_idle || ($urandom_range(0, 99) >= IDLE_PCT);
            end
        end
    end

    initial begin
        #2_000_000;
        $display("tb failed");
        $finish;
    end

    initial begin
        logic [BYTES_W-1:0] cap;
        ledger           = new();
        i_rst_n          = 1'b0;
        i_cfg_valid      = 1'b0;
        i_cfg_data       = '0;
        i_in_valid       = 1'b0;
        i_mode           = MODE_ADD;
        i_packet_length  = '0;
        i_packet_handle  = '0;
        i_extract_budget = '0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // reset capacity: empty queue, rejects, exact fill, zero budget, oversized head
        send_request(MODE_EXTRACT, '0, 16'h1234, BYTES_MAX);
        send_request(MODE_ADD, '0, 16'hAAAA, BYTES_MAX);
        send_request(MODE_ADD, 16'hFFFF, 16'h5555, '0);
        send_request(MODE_ADD, 16'd1, 16'hFFFF, '0);
        send_request(MODE_ADD, 16'd32767, 16'h0000, '0);
        send_request(MODE_ADD, 16'd1, 16'h0001, '0);
        send_request(MODE_EXTRACT, 16'hFFFF, 16'hFFFF, '0);
        send_request(MODE_EXTRACT, '0, '0, BYTES_W'(1));
        drain_results();

        // fill every slot, overflow once, then one maximal run
        write_capacity(BYTES_MAX);
        for (int i = 0; i < DEPTH - 1; i++)
            send_request(MODE_ADD, LEN_W'($urandom_range(1, 16)), HDL_W'($urandom), '0);
        send_request(MODE_ADD, 16'd8, 16'hBEEF, '0);
        send_request(MODE_EXTRACT, '0, '0, BYTES_MAX);

        for (int ph = 0; ph < PHASES; ph++) begin
            drain_results();
            case (ph)
                0:       cap = BYTES_MAX;
                1:       cap = '0;
                2:       cap = BYTES_W'(100);
                3:       cap = RESET_CAPACITY;
                4:       cap = BYTES_W'($urandom_range(1, BYTES_MAX));
                6:       cap = BYTES_W'(4096);
                default: cap = BYTES_MAX;
            endcase
            write_capacity(cap);
            no_idle = (ph == 3);
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                if (ph == 5 && n == 10) hold_req = 1'b1;
                if (ph == 2 && n == 30) drain_results();
                if (!no_idle)
                    while ($urandom_range(0, 99) < IDLE_PCT) pause_input();
                random_request();
            end
        end
        drain_results();

        $display("covered %0d requests, %0d result beats, longest extract run %0d",
                 ledger.requests, ledger.beats_seen, ledger.longest_run);
        $display("beats by status: added %0d, no room %0d, empty %0d, full %0d, delivered %0d, none %0d",
                 ledger.status_hits[0], ledger.status_hits[1], ledger.status_hits[2],
                 ledger.status_hits[3], ledger.status_hits[4], ledger.status_hits[5]);
        if (ledger.mismatches == 0) begin
            $display("tb passed");
        end else begin
            $display("tb failed");
        end
        $finish;
    end

endmodule

// ===== files.f =====
sv/bbpf_pkg.sv
sv/bbpf_ctrl.sv
sv/bbpf_dp.sv
sv/byte_budget_packet_fifo.sv
bench/tb.sv
